@@ design/rpe_pkg.sv @@
// Shared types, constants and lane helpers for the relocation patch engine.
// Standalone package; used by relocation_patch_engine.
`default_nettype none

package rpe_pkg;

   // Command codes on the request channel
   typedef enum logic [3:0] {
      CMD_ADDR32     = 4'd0,
      CMD_LO16       = 4'd1,
      CMD_HI16       = 4'd2,
      CMD_HA16       = 4'd3,
      CMD_REL24      = 4'd4,
      CMD_W32        = 4'd5,
      CMD_W16        = 4'd6,
      CMD_W8         = 4'd7,
      CMD_CONDPTR    = 4'd8,
      CMD_CW32       = 4'd9,
      CMD_CW16       = 4'd10,
      CMD_CW8        = 4'd11,
      CMD_BRANCH     = 4'd12,
      CMD_BRANCHLINK = 4'd13
   } command_type;

   localparam logic [31:0] ABS_TARGET_BIT = 32'h8000_0000;
   localparam logic [31:0] REL24_KEEP     = 32'hFC00_0003;
   localparam logic [31:0] REL24_FIELD    = 32'h03FF_FFFC;
   localparam logic [31:0] BRANCH_OPCODE  = 32'h4800_0000;
   localparam logic [31:0] BRANCHLINK_OP  = 32'h4800_0001;

   // Big-endian halfword lane: address bit 1 clear selects bits 31:16
   function automatic logic [31:0] put_half(input logic [31:0] word,
                                            input logic       low_lane,
                                            input logic [15:0] half);
      logic [31:0] res;
      res = low_lane ? {word[31:16], half} : {half, word[15:0]};
      return res;
   endfunction

   function automatic logic [15:0] get_half(input logic [31:0] word,
                                            input logic       low_lane);
      logic [15:0] res;
      res = low_lane ? word[15:0] : word[31:16];
      return res;
   endfunction

   // Big-endian byte lane: offset 0 is bits 31:24
   function automatic logic [31:0] put_byte(input logic [31:0] word,
                                            input logic [1:0] offs,
                                            input logic [7:0] b);
      logic [31:0] res;
      res = word;
      case (offs)
         2'd0:    res[31:24] = b;
         2'd1:    res[23:16] = b;
         2'd2:    res[15:8]  = b;
         default: res[7:0]   = b;
      endcase
      return res;
   endfunction

   function automatic logic [7:0] get_byte(input logic [31:0] word,
                                           input logic [1:0] offs);
      logic [7:0] res;
      case (offs)
         2'd0:    res = word[31:24];
         2'd1:    res = word[23:16];
         2'd2:    res = word[15:8];
         default: res = word[7:0];
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/relocation_patch_engine.sv @@
// Relocation patch engine: applies one relocation or patch command per item
// to a big-endian word memory. Depends on rpe_pkg.
//
// Latency: result register loads at the edge after the request transfer,
//   later only while an earlier result is still stalled on the rsp side.
// Flow: a new request is taken only once the last item has finished; the patch
//   memory is read at transfer, then modified and written back as the result loads.
// Reset: text base cleared; then a clearing pass writes zero to every memory
//   word, one per cycle, with req_stall held high.
`default_nettype none

module relocation_patch_engine
   import rpe_pkg::*;
#(
   parameter int MEM_WORDS_LOG2 = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_command,
   input  wire logic        req_use_absolute,
   input  wire logic [23:0] req_location_offset,
   input  wire logic [31:0] req_absolute_location,
   input  wire logic [31:0] req_operand_value,
   input  wire logic [31:0] req_expected_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_word_address,
   output logic [31:0]      rsp_word_after,
   output logic             rsp_wrote,
   output logic             rsp_unknown_command,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_text_base
);

   localparam int MEM_DEPTH = 1 << MEM_WORDS_LOG2;
   localparam int IDX_HI    = MEM_WORDS_LOG2 + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                 state_ff;
   logic [MEM_WORDS_LOG2-1:0] clr_idx_ff;
   logic [31:0]               text_base_ff;

   // captured item
   command_type               cmd_ff;
   logic [31:0]               loc_ff;
   logic [31:0]               target_ff;
   logic [31:0]               val_ff;
   logic [31:0]               expect_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_addr_ff;
   logic [31:0]               rsp_word_ff;
   logic                      rsp_wrote_ff;
   logic                      rsp_unknown_ff;

   // memory
   logic [31:0]               patch_mem [MEM_DEPTH];
   logic [31:0]               rd_data_ff;

   logic                      req_xfer;
   logic                      rsp_xfer;
   logic                      finish;
   logic [31:0]               loc_in;
   logic [31:0]               target_in;
   logic [MEM_WORDS_LOG2-1:0] rd_addr;
   logic                      mem_we;
   logic [MEM_WORDS_LOG2-1:0] wr_addr;
   logic [31:0]               wr_data;
   logic [31:0]               new_word;
   logic                      exec_wrote;
   logic                      exec_unknown;
   logic [31:0]               delta;
   logic [15:0]               ha_half;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign finish    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // location and resolved target at request transfer
   assign loc_in    = req_use_absolute ? req_absolute_location
                                       : text_base_ff + {8'd0, req_location_offset};
   assign target_in = ((req_operand_value & ABS_TARGET_BIT) != 32'd0)
                    ? req_operand_value : text_base_ff + req_operand_value;
   assign rd_addr   = loc_in[IDX_HI:2];

   // modify the word read back from memory
   assign delta   = target_ff - loc_ff;
   assign ha_half = target_ff[31:16] + {15'd0, target_ff[15]};

   always_comb begin
      new_word     = rd_data_ff;
      exec_wrote   = 1'b1;
      exec_unknown = 1'b0;
      case (cmd_ff)
         CMD_ADDR32: new_word = target_ff;
         CMD_LO16:   new_word = put_half(rd_data_ff, loc_ff[1], target_ff[15:0]);
         CMD_HI16:   new_word = put_half(rd_data_ff, loc_ff[1], target_ff[31:16]);
         CMD_HA16:   new_word = put_half(rd_data_ff, loc_ff[1], ha_half);
         CMD_REL24:  new_word = (rd_data_ff & REL24_KEEP) | (delta & REL24_FIELD);
         CMD_W32:    new_word = val_ff;
         CMD_W16:    new_word = put_half(rd_data_ff, loc_ff[1], val_ff[15:0]);
         CMD_W8:     new_word = put_byte(rd_data_ff, loc_ff[1:0], val_ff[7:0]);
         CMD_CONDPTR: begin
            if (rd_data_ff == expect_ff) new_word = target_ff;
            else exec_wrote = 1'b0;
         end
         CMD_CW32: begin
            if (rd_data_ff == expect_ff) new_word = val_ff;
            else exec_wrote = 1'b0;
         end
         CMD_CW16: begin
            if (get_half(rd_data_ff, loc_ff[1]) == expect_ff[15:0])
               new_word = put_half(rd_data_ff, loc_ff[1], val_ff[15:0]);
            else exec_wrote = 1'b0;
         end
         CMD_CW8: begin
            if (get_byte(rd_data_ff, loc_ff[1:0]) == expect_ff[7:0])
               new_word = put_byte(rd_data_ff, loc_ff[1:0], val_ff[7:0]);
            else exec_wrote = 1'b0;
         end
         CMD_BRANCH:     new_word = (BRANCH_OPCODE & REL24_KEEP) | (delta & REL24_FIELD);
         CMD_BRANCHLINK: new_word = (BRANCHLINK_OP & REL24_KEEP) | (delta & REL24_FIELD);
         default: begin
            exec_wrote   = 1'b0;
            exec_unknown = 1'b1;
         end
      endcase
   end

   // write port: clearing pass or write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we  = 1'b1;
         wr_addr = clr_idx_ff;
         wr_data = 32'd0;
      end else begin
         mem_we  = finish && exec_wrote;
         wr_addr = loc_ff[IDX_HI:2];
         wr_data = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         patch_mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data; the next transfer can come in the cycle after write-back
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= patch_mem[rd_addr];
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_base_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         text_base_ff <= csr_text_base;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + MEM_WORDS_LOG2'(1);
               if (clr_idx_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_xfer) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (finish) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_xfer) rsp_valid_ff <= 1'b0;
      end

      // payload
      if (req_xfer) begin
         cmd_ff    <= command_type'(req_command);
         loc_ff    <= loc_in;
         target_ff <= target_in;
         val_ff    <= req_operand_value;
         expect_ff <= req_expected_value;
      end
      if (finish) begin
         rsp_addr_ff    <= {loc_ff[31:2], 2'b00};
         rsp_word_ff    <= new_word;
         rsp_wrote_ff   <= exec_wrote;
         rsp_unknown_ff <= exec_unknown;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_word_address    = rsp_addr_ff;
   assign rsp_word_after      = rsp_word_ff;
   assign rsp_wrote           = rsp_wrote_ff;
   assign rsp_unknown_command = rsp_unknown_ff;

   // checks
   a_xfer_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_EXEC)
      else $error("request transfer did not start execution");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result valid during clearing pass");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result appeared without execution");

   a_unknown_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_wrote_ff && rsp_unknown_ff))
      else $error("unknown command reported a write");

endmodule

`default_nettype wire

@@ tb/relocation_patch_engine_tb.sv @@
// Self-checking testbench for relocation_patch_engine: random and directed patch
// commands against an in-bench big-endian memory predictor, under random stalls.
// Depends on rpe_pkg and the relocation_patch_engine RTL.
`default_nettype none

module relocation_patch_engine_tb
   import rpe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MEM_LOG2    = 12;
   localparam int          CYCLE_LIMIT = 200_000;
   localparam int          RAND_PHASES = 6;
   localparam int          PHASE_ITEMS = 75;
   localparam logic [3:0]  CMD_BAD_LO  = 4'd14;
   localparam logic [3:0]  CMD_BAD_HI  = 4'd15;
   localparam logic [31:0] LANE16      = 32'h0000_FFFF;
   localparam logic [31:0] LANE8       = 32'h0000_00FF;

   typedef struct packed {
      logic [3:0]  command;
      logic        use_absolute;
      logic [23:0] location_offset;
      logic [31:0] absolute_location;
      logic [31:0] operand_value;
      logic [31:0] expected_value;
   } patch_req_type;

   typedef struct packed {
      logic [31:0] word_address;
      logic [31:0] word_after;
      logic        wrote;
      logic        unknown_command;
   } patch_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid             = 1'b0;
   logic        req_stall;
   logic [3:0]  req_command           = '0;
   logic        req_use_absolute      = 1'b0;
   logic [23:0] req_location_offset   = '0;
   logic [31:0] req_absolute_location = '0;
   logic [31:0] req_operand_value     = '0;
   logic [31:0] req_expected_value    = '0;
   logic        rsp_valid;
   logic        rsp_stall             = 1'b0;
   logic [31:0] rsp_word_address;
   logic [31:0] rsp_word_after;
   logic        rsp_wrote;
   logic        rsp_unknown_command;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_text_base;

   // Predictor state, plus a lookahead copy used while building stimulus
   logic [31:0] text_base_q = '0;
   logic [31:0] patch_mem [1 << MEM_LOG2];
   logic [31:0] plan_mem  [1 << MEM_LOG2];

   patch_req_type  queued_patches [$];
   patch_rsp_type  due_results [$];
   patch_req_type  on_bus;

   int issued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int wrote_count    = 0;
   int unknown_count  = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit quiet          = 1'b0;

   relocation_patch_engine #(.MEM_WORDS_LOG2(MEM_LOG2)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_use_absolute      (req_use_absolute),
      .req_location_offset   (req_location_offset),
      .req_absolute_location (req_absolute_location),
      .req_operand_value     (req_operand_value),
      .req_expected_value    (req_expected_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_word_address      (rsp_word_address),
      .rsp_word_after        (rsp_word_after),
      .rsp_wrote             (rsp_wrote),
      .rsp_unknown_command   (rsp_unknown_command),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_text_base         (csr_text_base)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < (1 << MEM_LOG2); i++) begin
         patch_mem[i] = '0;
         plan_mem[i]  = '0;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] location_of(input patch_req_type it,
                                               input logic [31:0] base);
      return it.use_absolute ? it.absolute_location : base + {8'd0, it.location_offset};
   endfunction

   function automatic logic [MEM_LOG2-1:0] word_index(input logic [31:0] loc);
      return loc[MEM_LOG2+1:2];
   endfunction

   function automatic logic [31:0] set_lane(input logic [31:0] word, input logic [31:0] m,
                                            input logic [4:0] sh, input logic [31:0] v);
      return (word & ~(m << sh)) | ((v & m) << sh);
   endfunction

   function automatic logic [31:0] get_lane(input logic [31:0] word, input logic [31:0] m,
                                            input logic [4:0] sh);
      return (word >> sh) & m;
   endfunction

   // Branch displacement lands in bits 25:2, opcode and AA/LK bits kept
   function automatic logic [31:0] displace(input logic [31:0] word, input logic [31:0] loc,
                                            input logic [31:0] target);
      return (word & REL24_KEEP) | ((target - loc) & REL24_FIELD);
   endfunction

   function automatic patch_rsp_type apply_patch(input patch_req_type it,
                                                 input logic [31:0] base,
                                                 input logic [31:0] word);
      logic [31:0]   loc;
      logic [31:0]   target;
      logic [31:0]   ha_part;
      logic [4:0]    hsh;
      logic [4:0]    bsh;
      patch_rsp_type r;
      loc     = location_of(it, base);
      target  = ((it.operand_value & ABS_TARGET_BIT) != 0) ? it.operand_value
                                                            : base + it.operand_value;
      hsh     = loc[1] ? 5'd0 : 5'd16;
      bsh     = {~loc[1:0], 3'b000};
      // high-adjusted: carry from bit 15 so a signed low half adds back correctly
      ha_part = {16'd0, target[31:16]} + {31'd0, target[15]};
      r.word_address    = {loc[31:2], 2'b00};
      r.word_after      = word;
      r.wrote           = 1'b1;
      r.unknown_command = 1'b0;
      case (command_type'(it.command))
         CMD_ADDR32:     r.word_after = target;
         CMD_LO16:       r.word_after = set_lane(word, LANE16, hsh, target);
         CMD_HI16:       r.word_after = set_lane(word, LANE16, hsh, target >> 16);
         CMD_HA16:       r.word_after = set_lane(word, LANE16, hsh, ha_part);
         CMD_REL24:      r.word_after = displace(word, loc, target);
         CMD_W32:        r.word_after = it.operand_value;
         CMD_W16:        r.word_after = set_lane(word, LANE16, hsh, it.operand_value);
         CMD_W8:         r.word_after = set_lane(word, LANE8, bsh, it.operand_value);
         CMD_CONDPTR: begin
            if (word == it.expected_value) r.word_after = target;
            else r.wrote = 1'b0;
         end
         CMD_CW32: begin
            if (word == it.expected_value) r.word_after = it.operand_value;
            else r.wrote = 1'b0;
         end
         CMD_CW16: begin
            if (get_lane(word, LANE16, hsh) == (it.expected_value & LANE16))
               r.word_after = set_lane(word, LANE16, hsh, it.operand_value);
            else r.wrote = 1'b0;
         end
         CMD_CW8: begin
            if (get_lane(word, LANE8, bsh) == (it.expected_value & LANE8))
               r.word_after = set_lane(word, LANE8, bsh, it.operand_value);
            else r.wrote = 1'b0;
         end
         CMD_BRANCH:     r.word_after = displace(BRANCH_OPCODE, loc, target);
         CMD_BRANCHLINK: r.word_after = displace(BRANCHLINK_OP, loc, target);
         default: begin
            r.wrote           = 1'b0;
            r.unknown_command = 1'b1;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic patch_req_type mk(input logic [3:0] cmd, input logic use_abs,
                                        input logic [23:0] offs, input logic [31:0] absloc,
                                        input logic [31:0] val, input logic [31:0] expv);
      patch_req_type it;
      it.command           = cmd;
      it.use_absolute      = use_abs;
      it.location_offset   = offs;
      it.absolute_location = absloc;
      it.operand_value     = val;
      it.expected_value    = expv;
      return it;
   endfunction

   // Locations cluster on a few words so that later commands see earlier writes
   function automatic patch_req_type random_patch();
      patch_req_type it;
      int pick;
      pick                 = $urandom_range(0, 19);
      it.command           = 4'($urandom_range(0, 15));
      it.use_absolute      = ($urandom_range(0, 3) == 0);
      if (pick < 14)      it.location_offset = 24'($urandom_range(0, 63));
      else if (pick < 17) it.location_offset = 24'($urandom);
      else                it.location_offset = 24'hFF_FFFF - 24'($urandom_range(0, 63));
      if ($urandom_range(0, 2) != 0)
         it.absolute_location = text_base_q + 32'($urandom_range(0, 63));
      else
         it.absolute_location = $urandom;
      if ($urandom_range(0, 3) == 0) it.operand_value = 32'($urandom_range(0, 255));
      else                           it.operand_value = $urandom;
      it.expected_value    = $urandom;
      return it;
   endfunction

   // Queue one command; with hit set, a compare command is given the current lane
   task automatic queue_patch(input patch_req_type it, input bit hit);
      logic [31:0]   loc;
      logic [31:0]   word;
      patch_rsp_type r;
      loc  = location_of(it, text_base_q);
      word = plan_mem[word_index(loc)];
      if (hit) begin
         case (command_type'(it.command))
            CMD_CONDPTR, CMD_CW32: it.expected_value = word;
            CMD_CW16: it.expected_value[15:0] = 16'(get_lane(word, LANE16,
                                                            loc[1] ? 5'd0 : 5'd16));
            CMD_CW8:  it.expected_value[7:0] = 8'(get_lane(word, LANE8, {~loc[1:0], 3'b000}));
            default: ;
         endcase
      end
      r = apply_patch(it, text_base_q, word);
      if (r.wrote) plan_mem[word_index(loc)] = r.word_after;
      queued_patches.push_back(it);
      issued_count++;
   endtask

   task automatic drain();
      while (!(accepted_count == issued_count && due_results.size() == 0))
         @(posedge clock);
   endtask

   task automatic load_text_base(input logic [31:0] value);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_text_base <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      text_base_q  = value;
   endtask

   task automatic note_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      if (error_count < 40)
         $display("ERROR %0s: got %08h, want %08h (result %0d)", what, got, want,
                  checked_count);
      error_count++;
   endtask

   // ---------------------------------------------------------------- request driver
   always @(posedge clock) begin : drive_req
      logic [31:0]   loc;
      patch_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         // transfer accepted: run the predictor on it
         if (req_valid && !req_stall) begin
            loc  = location_of(on_bus, text_base_q);
            want = apply_patch(on_bus, text_base_q, patch_mem[word_index(loc)]);
            if (want.wrote) patch_mem[word_index(loc)] = want.word_after;
            due_results.push_back(want);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (queued_patches.size() != 0) begin
               on_bus                 = queued_patches.pop_front();
               req_valid             <= 1'b1;
               req_command           <= on_bus.command;
               req_use_absolute      <= on_bus.use_absolute;
               req_location_offset   <= on_bus.location_offset;
               req_absolute_location <= on_bus.absolute_location;
               req_operand_value     <= on_bus.operand_value;
               req_expected_value    <= on_bus.expected_value;
               send_gap              <= pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(posedge clock) begin : check_rsp
      patch_rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               note_error("result with no command outstanding", rsp_word_address, '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_word_address !== want.word_address)
                  note_error("word_address", rsp_word_address, want.word_address);
               if (rsp_word_after !== want.word_after)
                  note_error("word_after", rsp_word_after, want.word_after);
               if (rsp_wrote !== want.wrote)
                  note_error("wrote", {31'd0, rsp_wrote}, {31'd0, want.wrote});
               if (rsp_unknown_command !== want.unknown_command)
                  note_error("unknown_command", {31'd0, rsp_unknown_command},
                             {31'd0, want.unknown_command});
               checked_count++;
               if (want.wrote) wrote_count++;
               if (want.unknown_command) unknown_count++;
            end
         end
         // receiver back-pressure
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_pause();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : stimulus
      logic [31:0] phase_base;
      csr_valid     = 1'b0;
      csr_text_base = '0;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: each command, lane, wrap and compare hit/miss case; CW16 is hit only
      load_text_base(32'h0000_2000);
      queue_patch(mk(CMD_ADDR32, 1'b0, 24'h000000, $urandom, 32'h0000_0100, $urandom), 1'b0);
      queue_patch(mk(CMD_ADDR32, 1'b1, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, '0), 1'b0);
      queue_patch(mk(CMD_LO16, 1'b0, 24'h000006, '0, 32'hFFFF_1234, '0), 1'b0);
      queue_patch(mk(CMD_LO16, 1'b0, 24'h000004, '0, 32'h0000_8765, '0), 1'b0);
      queue_patch(mk(CMD_HI16, 1'b0, 24'h000008, '0, 32'h9234_5678, '0), 1'b0);
      queue_patch(mk(CMD_HA16, 1'b0, 24'h00000C, '0, 32'h8001_8000, '0), 1'b0);
      queue_patch(mk(CMD_HA16, 1'b0, 24'h00000E, '0, 32'hFFFF_8000, '0), 1'b0);
      queue_patch(mk(CMD_REL24, 1'b0, 24'h000010, '0, 32'h0000_0400, '0), 1'b0);
      queue_patch(mk(CMD_REL24, 1'b0, 24'hFF_FFFC, '0, 32'h0000_0000, '0), 1'b0);
      queue_patch(mk(CMD_W32, 1'b0, 24'h000014, '0, 32'hFFFF_FFFF, '0), 1'b0);
      queue_patch(mk(CMD_W16, 1'b0, 24'h000015, '0, 32'h0000_ABCD, '0), 1'b0);
      queue_patch(mk(CMD_W16, 1'b0, 24'h000017, '0, 32'hFFFF_5A5A, '0), 1'b0);
      queue_patch(mk(CMD_W8, 1'b0, 24'h000018, '0, 32'h0000_0011, '0), 1'b0);
      queue_patch(mk(CMD_W8, 1'b0, 24'h000019, '0, 32'h0000_0022, '0), 1'b0);
      queue_patch(mk(CMD_W8, 1'b0, 24'h00001A, '0, 32'h0000_0033, '0), 1'b0);
      queue_patch(mk(CMD_W8, 1'b0, 24'h00001B, '0, 32'hFFFF_FFFF, '0), 1'b0);
      queue_patch(mk(CMD_CONDPTR, 1'b0, 24'h000020, '0, 32'h0000_0040, '0), 1'b1);
      queue_patch(mk(CMD_CONDPTR, 1'b0, 24'h000020, '0, 32'h8000_0040, 32'hDEAD_BEEF), 1'b0);
      queue_patch(mk(CMD_CW32, 1'b0, 24'h000014, '0, 32'h1234_5678, '0), 1'b1);
      queue_patch(mk(CMD_CW32, 1'b0, 24'h000014, '0, 32'h0BAD_0BAD, '0), 1'b0);
      queue_patch(mk(CMD_CW16, 1'b0, 24'h000016, '0, 32'h0000_BEEF, '0), 1'b1);
      queue_patch(mk(CMD_CW8, 1'b0, 24'h000019, '0, 32'h0000_0077, '0), 1'b1);
      queue_patch(mk(CMD_CW8, 1'b0, 24'h00001A, '0, 32'h0000_0055, 32'h0000_00AA), 1'b0);
      queue_patch(mk(CMD_BRANCH, 1'b0, 24'h000024, '0, 32'h0000_0000, '0), 1'b0);
      queue_patch(mk(CMD_BRANCHLINK, 1'b1, '0, 32'h0000_0000, 32'hFFFF_FFFC, '0), 1'b0);
      queue_patch(mk(CMD_BAD_LO, 1'b0, 24'h000014, '0, $urandom, $urandom), 1'b0);
      queue_patch(mk(CMD_BAD_HI, 1'b1, '0, 32'hFFFF_FFFC, $urandom, $urandom), 1'b0);
      drain();

      // Random phases, each under its own text base
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0:       phase_base = 32'h0000_0000;
            1:       phase_base = 32'hFFFF_FFFF;
            2:       phase_base = 32'h8000_0000;
            3:       phase_base = 32'hFFFF_F000;
            default: phase_base = $urandom;
         endcase
         load_text_base(phase_base);
         quiet = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the pipeline is empty
            if (ph == 4 && n == PHASE_ITEMS / 2) drain();
            queue_patch(random_patch(), $urandom_range(0, 9) < 7);
         end
         drain();
      end
      quiet = 1'b0;

      repeat (10) @(posedge clock);
      if (due_results.size() != 0)
         note_error("results never returned", 32'(due_results.size()), '0);
      $display("Checked %0d patch transfers over %0d text base settings:", checked_count,
               RAND_PHASES + 1);
      $display("  %0d wrote memory, %0d flagged an unknown command", wrote_count,
               unknown_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
